// ----- hw/rtl/qfa_pkg.sv -----
package qfa_pkg;

    localparam int WordBits     = 32;
    localparam int FractionBits = 16;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_FLOOR = 4'd4;
    localparam logic [3:0] OP_FRAC  = 4'd5;
    localparam logic [3:0] OP_INC   = 4'd6;
    localparam logic [3:0] OP_DEC   = 4'd7;

    typedef struct packed {
        logic                valid;
        logic [3:0]          op;
        logic [WordBits-1:0] res;
        logic                less;
        logic                equal;
        logic                neg;
        logic                dz;
    } t_side;

endpackage

// ----- hw/rtl/qfa_div_stage.sv -----
module qfa_div_stage #(
    parameter int FRACTION_BITS = qfa_pkg::FractionBits
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  logic [qfa_pkg::WordBits-1:0]              i_rem,
    input  logic [qfa_pkg::WordBits+FRACTION_BITS-1:0] i_nq,
    input  logic [qfa_pkg::WordBits-1:0]              i_d,
    input  qfa_pkg::t_side                            i_side,
    output logic [qfa_pkg::WordBits-1:0]              o_rem,
    output logic [qfa_pkg::WordBits+FRACTION_BITS-1:0] o_nq,
    output logic [qfa_pkg::WordBits-1:0]              o_d,
    output qfa_pkg::t_side                            o_side
);

    localparam int NQ = qfa_pkg::WordBits + FRACTION_BITS;

    logic [qfa_pkg::WordBits:0]   w_trial;
    logic [qfa_pkg::WordBits:0]   w_diff;
    logic                         w_ge;
    logic [qfa_pkg::WordBits-1:0] n_rem;
    logic [NQ-1:0]                n_nq;

    logic [qfa_pkg::WordBits-1:0] r_rem;
    logic [NQ-1:0]                r_nq;
    logic [qfa_pkg::WordBits-1:0] r_d;
    qfa_pkg::t_side               r_side;

    assign w_trial = {i_rem, i_nq[NQ-1]};
    assign w_diff  = w_trial - {1'b0, i_d};
    assign w_ge    = w_trial >= {1'b0, i_d};
    assign n_rem   = w_ge ? w_diff[qfa_pkg::WordBits-1:0] : w_trial[qfa_pkg::WordBits-1:0];
    assign n_nq    = {i_nq[NQ-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side.valid <= i_side.valid;
        end
        if (i_en) begin
            r_rem        <= n_rem;
            r_nq         <= n_nq;
            r_d          <= i_d;
            r_side.op    <= i_side.op;
            r_side.res   <= i_side.res;
            r_side.less  <= i_side.less;
            r_side.equal <= i_side.equal;
            r_side.neg   <= i_side.neg;
            r_side.dz    <= i_side.dz;
        end
    end

    assign o_rem  = r_rem;
    assign o_nq   = r_nq;
    assign o_d    = r_d;
    assign o_side = r_side;

endmodule

// ----- hw/rtl/q16_16_fixed_point_alu_unit.sv -----
// Signed Q16.16 arithmetic unit: add, subtract, rounded multiply, truncating divide, floor,
// frac, increment and decrement, with signed less and equal flags on every word. It takes
// one word per cycle while not stalled. The divider resolves one quotient bit per stage
// over FRACTION_BITS + 32 stages between an input and an output register. Every operation
// travels the same pipeline, so results leave in order. A stall freezes the whole pipeline.
module q16_16_fixed_point_alu_unit #(
    parameter int FRACTION_BITS = qfa_pkg::FractionBits
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_opcode,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_value,
    output logic               o_a_less,
    output logic               o_a_equal,
    output logic               o_divide_by_zero
);

    localparam int W  = qfa_pkg::WordBits;
    localparam int NQ = W + FRACTION_BITS;
    localparam logic [2*W-1:0] HalfLsb  = (2*W)'(1) << (FRACTION_BITS - 1);
    localparam logic [W-1:0]   OneRaw   = W'(1) << FRACTION_BITS;
    localparam logic [W-1:0]   FracMask = OneRaw - W'(1);

    logic w_en;

    logic         r_in_valid;
    logic [3:0]   r_op;
    logic [W-1:0] r_a;
    logic [W-1:0] r_b;

    logic signed [2*W-1:0] r_prod;
    logic [2*W-1:0]        w_prod_rnd;

    qfa_pkg::t_side w_side0;
    logic [W-1:0]   w_mag_a;
    logic [W-1:0]   w_mag_b;

    logic [W-1:0]   s_rem  [NQ];
    logic [NQ-1:0]  s_nq   [NQ];
    logic [W-1:0]   s_d    [NQ];
    qfa_pkg::t_side s_side [NQ];
    qfa_pkg::t_side w_side1;

    qfa_pkg::t_side w_last;
    logic [NQ-1:0]  w_q_signed;
    logic [W-1:0]   n_res;

    logic         r_o_valid;
    logic [W-1:0] r_o_res;
    logic         r_o_less;
    logic         r_o_equal;
    logic         r_o_dz;

    assign w_en    = !r_o_valid || !i_stall;
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_valid;
        end
        if (w_en) begin
            r_op <= i_opcode;
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
        end
    end

    always_comb begin
        w_mag_a = r_a[W-1] ? (W'(0) - r_a) : r_a;
        w_mag_b = r_b[W-1] ? (W'(0) - r_b) : r_b;
        w_side0.valid = r_in_valid;
        w_side0.op    = r_op;
        w_side0.less  = $signed(r_a) < $signed(r_b);
        w_side0.equal = r_a == r_b;
        w_side0.neg   = r_a[W-1] ^ r_b[W-1];
        w_side0.dz    = (r_op == qfa_pkg::OP_DIV) && (r_b == W'(0));
        unique case (r_op)
            qfa_pkg::OP_ADD:   w_side0.res = r_a + r_b;
            qfa_pkg::OP_SUB:   w_side0.res = r_a - r_b;
            qfa_pkg::OP_MUL:   w_side0.res = W'(0);
            qfa_pkg::OP_DIV:   w_side0.res = W'(0);
            qfa_pkg::OP_FLOOR: w_side0.res = r_a & ~FracMask;
            qfa_pkg::OP_FRAC:  w_side0.res = r_a & FracMask;
            qfa_pkg::OP_INC:   w_side0.res = r_a + OneRaw;
            qfa_pkg::OP_DEC:   w_side0.res = r_a - OneRaw;
            default:           w_side0.res = r_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= $signed(r_a) * $signed(r_b);
        end
    end

    assign w_prod_rnd = r_prod + HalfLsb;

    always_comb begin
        w_side1 = s_side[0];
        if (s_side[0].op == qfa_pkg::OP_MUL) begin
            w_side1.res = w_prod_rnd[FRACTION_BITS +: W];
        end
    end

    genvar g;
    generate
        for (g = 0; g < NQ; g++) begin : g_div
            if (g == 0) begin : g_first
                qfa_div_stage #(.FRACTION_BITS(FRACTION_BITS)) u_stage (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_en   (w_en),
                    .i_rem  (W'(0)),
                    .i_nq   ({w_mag_a, FRACTION_BITS'(0)}),
                    .i_d    (w_mag_b),
                    .i_side (w_side0),
                    .o_rem  (s_rem[g]),
                    .o_nq   (s_nq[g]),
                    .o_d    (s_d[g]),
                    .o_side (s_side[g])
                );
            end else if (g == 1) begin : g_second
                qfa_div_stage #(.FRACTION_BITS(FRACTION_BITS)) u_stage (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_en   (w_en),
                    .i_rem  (s_rem[g-1]),
                    .i_nq   (s_nq[g-1]),
                    .i_d    (s_d[g-1]),
                    .i_side (w_side1),
                    .o_rem  (s_rem[g]),
                    .o_nq   (s_nq[g]),
                    .o_d    (s_d[g]),
                    .o_side (s_side[g])
                );
            end else begin : g_rest
                qfa_div_stage #(.FRACTION_BITS(FRACTION_BITS)) u_stage (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_en   (w_en),
                    .i_rem  (s_rem[g-1]),
                    .i_nq   (s_nq[g-1]),
                    .i_d    (s_d[g-1]),
                    .i_side (s_side[g-1]),
                    .o_rem  (s_rem[g]),
                    .o_nq   (s_nq[g]),
                    .o_d    (s_d[g]),
                    .o_side (s_side[g])
                );
            end
        end
    endgenerate

    assign w_last     = s_side[NQ-1];
    assign w_q_signed = w_last.neg ? (NQ'(0) - s_nq[NQ-1]) : s_nq[NQ-1];

    always_comb begin
        n_res = w_last.res;
        if (w_last.op == qfa_pkg::OP_DIV) begin
            n_res = w_last.dz ? W'(0) : w_q_signed[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_last.valid;
        end
        if (w_en) begin
            r_o_res   <= n_res;
            r_o_less  <= w_last.less;
            r_o_equal <= w_last.equal;
            r_o_dz    <= w_last.dz;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_result_value   = r_o_res;
    assign o_a_less         = r_o_less;
    assign o_a_equal        = r_o_equal;
    assign o_divide_by_zero = r_o_dz;

endmodule
